FILE: hw/rtl/cgal_pkg.sv
// Shared types and constants for the glyph atlas locator pipeline.
package cgal_pkg;

   typedef enum logic [1:0] {
      MODE_WESTERN = 2'd0,
      MODE_KOREAN  = 2'd1,
      MODE_BIG5    = 2'd2,
      MODE_SJIS    = 2'd3
   } mode_type;

   localparam logic [1:0] CSR_LANGUAGE_MODE   = 2'd0;
   localparam logic [1:0] CSR_ACROSS_LOG2     = 2'd1;
   localparam logic [1:0] CSR_PAGES_LOADED    = 2'd2;
   localparam logic [1:0] CSR_LAST_PAGE_HALF  = 2'd3;

   localparam logic [7:0] KSC_LEAD_FIRST   = 8'hB0;
   localparam logic [7:0] KSC_LEAD_LAST    = 8'hC8;
   localparam logic [7:0] KSC_TRAIL_BASE   = 8'hA0;
   localparam logic [7:0] KSC_TRAIL_LAST   = 8'hFE;
   localparam logic [7:0] KSC_ROW_LEN      = 8'd96;

   localparam logic [7:0] BIG5_LEAD_FIRST  = 8'hA1;
   localparam logic [7:0] BIG5_LEAD_GAP_LO = 8'hC6;
   localparam logic [7:0] BIG5_LEAD_GAP_HI = 8'hC9;
   localparam logic [7:0] BIG5_LEAD_LAST   = 8'hF9;
   localparam logic [7:0] BIG5_TRAIL_GAP_LO = 8'h7E;
   localparam logic [7:0] BIG5_TRAIL_GAP_HI = 8'hA1;
   localparam logic [7:0] BIG5_TRAIL_LAST  = 8'hFE;
   localparam logic [7:0] BIG5_TRAIL_FOLD  = 8'h60;
   localparam logic [7:0] BIG5_TRAIL_SKIP  = 8'h20;
   localparam logic [7:0] BIG5_ROW_LEN     = 8'd160;

   localparam logic [7:0] SJIS_LEAD_FIRST  = 8'h81;
   localparam logic [7:0] SJIS_LEAD_GAP_LO = 8'h9F;
   localparam logic [7:0] SJIS_LEAD_GAP_HI = 8'hE0;
   localparam logic [7:0] SJIS_LEAD_LAST   = 8'hEF;
   localparam logic [7:0] SJIS_LEAD_FOLD   = 8'h5F;
   localparam logic [7:0] SJIS_LEAD_SKIP   = 8'h40;
   localparam logic [7:0] SJIS_TRAIL_GAP_LO = 8'h7E;
   localparam logic [7:0] SJIS_TRAIL_GAP_HI = 8'h80;
   localparam logic [7:0] SJIS_TRAIL_LAST  = 8'hFC;
   localparam logic [7:0] SJIS_ROW_LEN     = 8'd188;

   localparam logic [7:0] TRAIL_BASE       = 8'h40;

   localparam logic [11:0] TEXELS          = 12'd1024;

   typedef struct packed {
      logic valid;
      logic load;
   } stage_ctl_type;

   typedef struct packed {
      logic       ok;
      mode_type   mode;
      logic [6:0] lead_off;
      logic [7:0] trail_off;
      logic [7:0] western;
   } dec_type;

   typedef struct packed {
      logic        asian;
      mode_type    mode;
      logic [13:0] idx;
      logic [7:0]  western;
   } col_type;

   typedef struct packed {
      logic        asian;
      mode_type    mode;
      logic [13:0] idx;
      logic [3:0]  page;
      logic [5:0]  col;
      logic [5:0]  row;
      logic        half;
      logic        lg6;
      logic [7:0]  western;
   } loc_type;

   typedef struct packed {
      logic        is_asian;
      logic [13:0] collapsed_index;
      logic [3:0]  page_index;
      logic [5:0]  glyph_column;
      logic [5:0]  glyph_row;
      logic [10:0] s_left;
      logic [10:0] t_top;
      logic [10:0] s_right;
      logic [10:0] t_bottom;
      logic [7:0]  western_index;
   } rsp_type;

endpackage

FILE: hw/rtl/cgal_decode.sv
// Stage one: validate lead and trail bytes per language mode and offset them.
module cgal_decode
   import cgal_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  logic [15:0]   char_code,
   input  mode_type      mode,
   input  logic [3:0]    pages_loaded,
   output logic          valid,
   output dec_type       data
);

   logic       valid_ff;
   dec_type    data_ff;
   dec_type    data_in;
   logic [7:0] hi;
   logic [7:0] lo;
   logic [7:0] lead_diff;
   logic [7:0] trail_diff;
   logic       hok;
   logic       lok;

   assign hi = char_code[15:8];
   assign lo = char_code[7:0];

   always_comb begin
      lead_diff  = 8'd0;
      trail_diff = 8'd0;
      hok        = 1'b0;
      lok        = 1'b0;
      unique case (mode)
         MODE_KOREAN: begin
            hok        = (hi >= KSC_LEAD_FIRST) && (hi <= KSC_LEAD_LAST);
            lok        = (lo > KSC_TRAIL_BASE) && (lo <= KSC_TRAIL_LAST);
            lead_diff  = hi - KSC_LEAD_FIRST;
            trail_diff = lo - KSC_TRAIL_BASE;
         end
         MODE_BIG5: begin
            hok = ((hi >= BIG5_LEAD_FIRST) && (hi <= BIG5_LEAD_GAP_LO)) ||
                  ((hi >= BIG5_LEAD_GAP_HI) && (hi <= BIG5_LEAD_LAST));
            lok = ((lo >= TRAIL_BASE) && (lo <= BIG5_TRAIL_GAP_LO)) ||
                  ((lo >= BIG5_TRAIL_GAP_HI) && (lo <= BIG5_TRAIL_LAST));
            lead_diff  = hi - BIG5_LEAD_FIRST;
            trail_diff = lo - TRAIL_BASE;
            if (trail_diff >= BIG5_TRAIL_FOLD) begin
               trail_diff = trail_diff - BIG5_TRAIL_SKIP;
            end
         end
         MODE_SJIS: begin
            hok = ((hi >= SJIS_LEAD_FIRST) && (hi <= SJIS_LEAD_GAP_LO)) ||
                  ((hi >= SJIS_LEAD_GAP_HI) && (hi <= SJIS_LEAD_LAST));
            lok = ((lo >= TRAIL_BASE) && (lo <= SJIS_TRAIL_GAP_LO)) ||
                  ((lo >= SJIS_TRAIL_GAP_HI) && (lo <= SJIS_TRAIL_LAST));
            lead_diff  = hi - SJIS_LEAD_FIRST;
            trail_diff = lo - TRAIL_BASE;
            if (trail_diff >= TRAIL_BASE) begin
               trail_diff = trail_diff - 8'd1;
            end
            if (lead_diff >= SJIS_LEAD_FOLD) begin
               lead_diff = lead_diff - SJIS_LEAD_SKIP;
            end
         end
         MODE_WESTERN: begin
            hok = 1'b0;
            lok = 1'b0;
         end
      endcase
      data_in.ok        = hok && lok && (pages_loaded != 4'd0);
      data_in.mode      = mode;
      data_in.lead_off  = lead_diff[6:0];
      data_in.trail_off = trail_diff;
      data_in.western   = lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

FILE: hw/rtl/cgal_collapse.sv
// Stage two: fold lead and trail offsets into one dense glyph index.
module cgal_collapse
   import cgal_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  dec_type       src,
   output logic          valid,
   output col_type       data
);

   logic        valid_ff;
   col_type     data_ff;
   col_type     data_in;
   logic [7:0]  row_len;
   logic [14:0] product;
   logic [14:0] sum;

   always_comb begin
      unique case (src.mode)
         MODE_KOREAN:  row_len = KSC_ROW_LEN;
         MODE_BIG5:    row_len = BIG5_ROW_LEN;
         MODE_SJIS:    row_len = SJIS_ROW_LEN;
         MODE_WESTERN: row_len = 8'd0;
      endcase
      product         = {8'd0, src.lead_off} * {7'd0, row_len};
      sum             = product + {7'd0, src.trail_off};
      data_in.asian   = src.ok && (sum != 15'd0);
      data_in.mode    = src.mode;
      data_in.idx     = sum[13:0];
      data_in.western = src.western;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

FILE: hw/rtl/cgal_locate.sv
// Stage three: split the glyph index into page, column and row.
module cgal_locate
   import cgal_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  col_type       src,
   input  logic [2:0]    across_log2,
   input  logic [3:0]    pages_loaded,
   input  logic          last_page_half,
   output logic          valid,
   output loc_type       data
);

   logic       valid_ff;
   loc_type    data_ff;
   loc_type    data_in;
   logic       lg6;
   logic [3:0] page_raw;
   logic [3:0] page;

   always_comb begin
      lg6      = across_log2 > 3'd5;
      page_raw = lg6 ? {2'b00, src.idx[13:12]} : src.idx[13:10];
      page     = (page_raw >= pages_loaded) ? 4'd0 : page_raw;
      data_in.asian   = src.asian;
      data_in.mode    = src.mode;
      data_in.lg6     = lg6;
      data_in.western = src.western;
      if (src.asian) begin
         data_in.idx  = src.idx;
         data_in.page = page;
         data_in.col  = lg6 ? src.idx[5:0] : {1'b0, src.idx[4:0]};
         data_in.row  = lg6 ? src.idx[11:6] : {1'b0, src.idx[9:5]};
         data_in.half = last_page_half && (page == (pages_loaded - 4'd1));
      end else begin
         data_in.idx  = 14'd0;
         data_in.page = 4'd0;
         data_in.col  = 6'd0;
         data_in.row  = 6'd0;
         data_in.half = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

FILE: hw/rtl/cgal_texel.sv
// Stage four: texel corners of the glyph cell, held as the output word.
module cgal_texel
   import cgal_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  loc_type       src,
   output logic          valid,
   output rsp_type       data
);

   logic        valid_ff;
   rsp_type     data_ff;
   rsp_type     data_in;
   logic [2:0]  shift_s;
   logic [2:0]  shift_t;
   logic [11:0] col_w;
   logic [11:0] row_w;
   logic [11:0] s0;
   logic [11:0] t0;
   logic [11:0] s1;
   logic [11:0] t1;

   function automatic logic [10:0] sat_texel(input logic [11:0] v);
      logic [11:0] r;
      r = (v > TEXELS) ? TEXELS : v;
      return r[10:0];
   endfunction

   always_comb begin
      shift_s = src.lg6 ? 3'd4 : 3'd5;
      shift_t = shift_s + {2'b00, src.half};
      col_w   = {6'd0, src.col};
      row_w   = {6'd0, src.row};
      s0 = col_w << shift_s;
      t0 = row_w << shift_t;
      s1 = (col_w + 12'd1) << shift_s;
      t1 = (row_w + 12'd1) << shift_t;
      unique case (src.mode)
         MODE_BIG5: begin
            s0 = s0 + 12'd1;
            t0 = t0 + 12'd1;
         end
         MODE_SJIS: begin
            s1 = s1 - 12'd1;
            t1 = t1 - 12'd1;
         end
         MODE_KOREAN, MODE_WESTERN: begin
            s0 = s0;
         end
      endcase
      data_in.is_asian        = src.asian;
      data_in.collapsed_index = src.idx;
      data_in.page_index      = src.page;
      data_in.glyph_column    = src.col;
      data_in.glyph_row       = src.row;
      data_in.western_index   = src.western;
      if (src.asian) begin
         data_in.s_left   = sat_texel(s0);
         data_in.t_top    = sat_texel(t0);
         data_in.s_right  = sat_texel(s1);
         data_in.t_bottom = sat_texel(t1);
      end else begin
         data_in.s_left   = 11'd0;
         data_in.t_top    = 11'd0;
         data_in.s_right  = 11'd0;
         data_in.t_bottom = 11'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         data_ff <= data_in;
      end
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

FILE: hw/rtl/cjk_glyph_atlas_locator_unit.sv
// Top level of the glyph atlas locator: config registers and four-stage pipeline.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid/req_ready   | char_code
//   rsp     | out       | rsp_valid/rsp_ready   | atlas location and texel corners
//   csr     | in        | csr_write             | index, data (no read-back)
//
// One word per cycle sustained while rsp_ready stays high; each word passes through four
// register stages in order: decode, index multiply, page split, texel corners;
// the last stage is the output register.
// Reset clears all stage valid bits and loads config reset values.
// A low rsp_ready stalls the output; a stage loads while it is empty or the
// stage after it loads, so bubbles are squeezed out.
module cjk_glyph_atlas_locator_unit
   import cgal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_asian,
   output logic [13:0] rsp_collapsed_index,
   output logic [3:0]  rsp_page_index,
   output logic [5:0]  rsp_glyph_column,
   output logic [5:0]  rsp_glyph_row,
   output logic [10:0] rsp_s_left,
   output logic [10:0] rsp_t_top,
   output logic [10:0] rsp_s_right,
   output logic [10:0] rsp_t_bottom,
   output logic [7:0]  rsp_western_index,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);

   mode_type      mode_ff;
   logic [2:0]    across_ff;
   logic [3:0]    pages_ff;
   logic          half_ff;

   stage_ctl_type ctl1;
   stage_ctl_type ctl2;
   stage_ctl_type ctl3;
   stage_ctl_type ctl4;
   logic          v1;
   logic          v2;
   logic          v3;
   logic          v4;
   logic          load1;
   logic          load2;
   logic          load3;
   logic          load4;
   dec_type       d1;
   col_type       d2;
   loc_type       d3;
   rsp_type       d4;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_WESTERN;
         across_ff <= 3'd6;
         pages_ff  <= 4'd0;
         half_ff   <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LANGUAGE_MODE:  mode_ff   <= mode_type'(csr_data[1:0]);
            CSR_ACROSS_LOG2:    across_ff <= csr_data[2:0];
            CSR_PAGES_LOADED:   pages_ff  <= csr_data;
            CSR_LAST_PAGE_HALF: half_ff   <= csr_data[0];
         endcase
      end
   end

   assign load4 = !v4 || rsp_ready;
   assign load3 = !v3 || load4;
   assign load2 = !v2 || load3;
   assign load1 = !v1 || load2;

   assign ctl1 = '{valid: req_valid, load: load1};
   assign ctl2 = '{valid: v1, load: load2};
   assign ctl3 = '{valid: v2, load: load3};
   assign ctl4 = '{valid: v3, load: load4};

   assign req_ready = load1;

   cgal_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl1),
      .char_code    (req_char_code),
      .mode         (mode_ff),
      .pages_loaded (pages_ff),
      .valid        (v1),
      .data         (d1)
   );

   cgal_collapse u_collapse (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl2),
      .src   (d1),
      .valid (v2),
      .data  (d2)
   );

   cgal_locate u_locate (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl3),
      .src            (d2),
      .across_log2    (across_ff),
      .pages_loaded   (pages_ff),
      .last_page_half (half_ff),
      .valid          (v3),
      .data           (d3)
   );

   cgal_texel u_texel (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl4),
      .src   (d3),
      .valid (v4),
      .data  (d4)
   );

   assign rsp_valid           = v4;
   assign rsp_is_asian        = d4.is_asian;
   assign rsp_collapsed_index = d4.collapsed_index;
   assign rsp_page_index      = d4.page_index;
   assign rsp_glyph_column    = d4.glyph_column;
   assign rsp_glyph_row       = d4.glyph_row;
   assign rsp_s_left          = d4.s_left;
   assign rsp_t_top           = d4.t_top;
   assign rsp_s_right         = d4.s_right;
   assign rsp_t_bottom        = d4.t_bottom;
   assign rsp_western_index   = d4.western_index;

`ifndef SYNTHESIS
   a_western_no_corners: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_asian |->
         (rsp_s_left == 11'd0) && (rsp_t_top == 11'd0) &&
         (rsp_s_right == 11'd0) && (rsp_t_bottom == 11'd0))
      else $error("western word carries texel corners");

   a_western_no_cell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_asian |->
         (rsp_collapsed_index == 14'd0) && (rsp_page_index == 4'd0) &&
         (rsp_glyph_column == 6'd0) && (rsp_glyph_row == 6'd0))
      else $error("western word carries atlas cell");

   a_asian_nonzero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_asian |-> (rsp_collapsed_index != 14'd0))
      else $error("atlas glyph with zero index");

   a_asian_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_asian |-> (rsp_s_left < rsp_s_right))
      else $error("glyph cell has no width");
`endif

endmodule
